// File: design/tli_pkg.sv
// shared constants, types and command/status structs for the table interpolator
package tli_pkg;

  // table and number format
  localparam int TABLE_DEPTH = 256;
  localparam int FRAC_BITS   = 16;
  localparam int DATA_W      = 32;
  localparam int IDX_W       = 8;
  localparam int CNT_W       = 9;
  localparam int ADDR_W      = $clog2(TABLE_DEPTH);
  localparam int PTR_W       = $clog2(TABLE_DEPTH + 1);

  // arithmetic widths: magnitudes, product, sum before saturation
  localparam int MAG_W  = DATA_W + 1;
  localparam int PROD_W = 2 * MAG_W;
  localparam int SUM_W  = PROD_W + 2;
  localparam int STEP_W = $clog2(PROD_W);

  // not-found value, minus 999 in fixed point, saturated to the data width
  localparam longint SENT_FULL = -64'sd999 * (64'sd1 <<< FRAC_BITS);
  localparam longint DATA_MIN  = -(64'sd1 <<< (DATA_W - 1));
  localparam logic signed [DATA_W-1:0] SENTINEL =
    (SENT_FULL < DATA_MIN) ? DATA_W'(DATA_MIN) : DATA_W'(SENT_FULL);

  // request function codes
  localparam logic FUNC_WRITE = 1'b0;
  localparam logic FUNC_QUERY = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_PREP,
    ST_MUL,
    ST_DIV,
    ST_FIN
  } state_t;

  typedef struct packed {
    logic wr;
    logic start;
    logic scan;
    logic prep;
    logic mul;
    logic div;
    logic fin;
  } cmd_t;

  typedef struct packed {
    logic few;
    logic hit;
    logic miss;
    logic direct;
    logic step_last;
    logic out_free;
  } stat_t;

endpackage

// File: design/tli_in_if.sv
// request channel: write or query with handshake
interface tli_in_if;
  logic                                 valid;
  logic                                 ready;
  logic                                 func;
  logic        [tli_pkg::IDX_W-1:0]     entry_index;
  logic signed [tli_pkg::DATA_W-1:0]    entry_x;
  logic signed [tli_pkg::DATA_W-1:0]    entry_y;
  logic signed [tli_pkg::DATA_W-1:0]    query_x;

  modport source (output valid, func, entry_index, entry_x, entry_y, query_x, input ready);
  modport sink   (input valid, func, entry_index, entry_x, entry_y, query_x, output ready);
endinterface

// File: design/tli_out_if.sv
// result channel: interpolated value and found flag with handshake
interface tli_out_if;
  logic                              valid;
  logic                              ready;
  logic signed [tli_pkg::DATA_W-1:0] value;
  logic                              found;

  modport source (output valid, value, found, input ready);
  modport sink   (input valid, value, found, output ready);
endinterface

// File: design/tli_ctrl.sv
// controller state machine: sequences scan, multiply, divide and result load
module tli_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  input  logic           in_func,
  output logic           in_ready,
  input  tli_pkg::stat_t st,
  output tli_pkg::cmd_t  cmd
);

  tli_pkg::state_t state_r, state_nxt;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= tli_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      tli_pkg::ST_IDLE: begin
        if (in_valid && in_func == tli_pkg::FUNC_QUERY) begin
          state_nxt = st.few ? tli_pkg::ST_FIN : tli_pkg::ST_SCAN;
        end
      end
      tli_pkg::ST_SCAN: begin
        if (st.hit) begin
          state_nxt = tli_pkg::ST_PREP;
        end else if (st.miss) begin
          state_nxt = tli_pkg::ST_FIN;
        end
      end
      tli_pkg::ST_PREP: begin
        state_nxt = st.direct ? tli_pkg::ST_FIN : tli_pkg::ST_MUL;
      end
      tli_pkg::ST_MUL: begin
        if (st.step_last) begin
          state_nxt = tli_pkg::ST_DIV;
        end
      end
      tli_pkg::ST_DIV: begin
        if (st.step_last) begin
          state_nxt = tli_pkg::ST_FIN;
        end
      end
      tli_pkg::ST_FIN: begin
        if (st.out_free) begin
          state_nxt = tli_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = tli_pkg::ST_IDLE;
      end
    endcase
  end

  // commands to the datapath
  always_comb begin
    in_ready  = (state_r == tli_pkg::ST_IDLE);
    cmd.wr    = in_valid && in_ready && (in_func == tli_pkg::FUNC_WRITE);
    cmd.start = in_valid && in_ready && (in_func == tli_pkg::FUNC_QUERY);
    cmd.scan  = (state_r == tli_pkg::ST_SCAN);
    cmd.prep  = (state_r == tli_pkg::ST_PREP);
    cmd.mul   = (state_r == tli_pkg::ST_MUL);
    cmd.div   = (state_r == tli_pkg::ST_DIV);
    cmd.fin   = (state_r == tli_pkg::ST_FIN);
  end

  // multiply always hands over to divide, never skips back
  a_mul_to_div: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == tli_pkg::ST_MUL) |=>
      (state_r == tli_pkg::ST_MUL || state_r == tli_pkg::ST_DIV))
    else $error("multiply state left to something other than divide");

endmodule

// File: design/tli_dpath.sv
// datapath: breakpoint memory, segment scan, shift-add multiply, restoring divide
module tli_dpath (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_we,
  input  logic        [tli_pkg::CNT_W-1:0]   cfg_wdata,
  input  tli_pkg::cmd_t                      cmd,
  output tli_pkg::stat_t                     st,
  input  logic        [tli_pkg::IDX_W-1:0]   entry_index,
  input  logic signed [tli_pkg::DATA_W-1:0]  entry_x,
  input  logic signed [tli_pkg::DATA_W-1:0]  entry_y,
  input  logic signed [tli_pkg::DATA_W-1:0]  query_x,
  input  logic                               out_ready,
  output logic                               out_valid,
  output logic signed [tli_pkg::DATA_W-1:0]  out_value,
  output logic                               out_found
);

  localparam int DW = tli_pkg::DATA_W;
  localparam int MW = tli_pkg::MAG_W;
  localparam int PW = tli_pkg::PROD_W;
  localparam int SW = tli_pkg::SUM_W;
  localparam int TW = tli_pkg::STEP_W;
  localparam int AW = tli_pkg::ADDR_W;
  localparam int RW = tli_pkg::PTR_W;

  // breakpoint memories
  logic signed [DW-1:0] mem_x [tli_pkg::TABLE_DEPTH];
  logic signed [DW-1:0] mem_y [tli_pkg::TABLE_DEPTH];

  logic [tli_pkg::CNT_W-1:0] points_r;
  logic [RW-1:0] n_eff;
  logic [RW-1:0] rd_addr_r, ridx_r;
  logic          rvalid_r;
  logic          issue;
  logic          wr_ok;
  logic [AW-1:0] wr_addr;
  logic signed [DW-1:0] rd_x_r, rd_y_r, prev_x_r, prev_y_r;
  logic signed [DW-1:0] qx_r, x0_r, y0_r, x1_r, y1_r;
  logic          bracket, hit, last_idx;
  logic          found_r, direct_r, neg_r;

  logic signed [MW-1:0] dx, dy, dd;
  logic [MW-1:0] mag_dx, mag_dy, mag_dd;

  logic [PW-1:0] mc_r, acc_r, acc_nxt, q_r;
  logic [MW-1:0] mp_r, dv_r, rem_r;
  logic [MW:0]   rem_sh, rem_diff;
  logic          ge;
  logic [TW-1:0] step_r;

  logic signed [SW-1:0] y0e, qe, sum;
  logic          ovf;
  logic signed [DW-1:0] fin_value;

  logic          out_valid_r;
  logic signed [DW-1:0] out_value_r;
  logic          out_found_r;

  // point count register, clipped to the table depth
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      points_r <= '0;
    end else if (cfg_we) begin
      points_r <= cfg_wdata;
    end
  end

  always_comb begin
    if (int'(points_r) > tli_pkg::TABLE_DEPTH) begin
      n_eff = RW'(tli_pkg::TABLE_DEPTH);
    end else begin
      n_eff = RW'(points_r);
    end
  end

  // memory write and registered scan read
  assign wr_ok   = int'(entry_index) < tli_pkg::TABLE_DEPTH;
  assign wr_addr = AW'(entry_index);
  assign issue   = cmd.scan && (rd_addr_r < n_eff);

  always_ff @(posedge clk) begin
    if (cmd.wr && wr_ok) begin
      mem_x[wr_addr] <= entry_x;
      mem_y[wr_addr] <= entry_y;
    end
    if (issue) begin
      rd_x_r <= mem_x[rd_addr_r[AW-1:0]];
      rd_y_r <= mem_y[rd_addr_r[AW-1:0]];
    end
  end

  // segment compare between previous and current entry
  assign bracket = ((qx_r >= prev_x_r) && (qx_r <= rd_x_r)) ||
                   ((qx_r <= prev_x_r) && (qx_r >= rd_x_r));
  assign hit      = cmd.scan && rvalid_r && (ridx_r != '0) && bracket;
  assign last_idx = (ridx_r == n_eff - RW'(1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rvalid_r <= 1'b0;
    end else begin
      rvalid_r <= issue;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      qx_r      <= query_x;
      rd_addr_r <= '0;
      found_r   <= 1'b0;
    end
    if (issue) begin
      rd_addr_r <= rd_addr_r + RW'(1);
      ridx_r    <= rd_addr_r;
    end
    if (cmd.scan && rvalid_r) begin
      prev_x_r <= rd_x_r;
      prev_y_r <= rd_y_r;
    end
    if (hit) begin
      found_r <= 1'b1;
      x0_r    <= prev_x_r;
      y0_r    <= prev_y_r;
      x1_r    <= rd_x_r;
      y1_r    <= rd_y_r;
    end
  end

  // operand preparation: differences, magnitudes and result sign
  assign dx = MW'(qx_r) - MW'(x0_r);
  assign dy = MW'(y1_r) - MW'(y0_r);
  assign dd = MW'(x1_r) - MW'(x0_r);
  assign mag_dx = dx[MW-1] ? MW'(-dx) : MW'(dx);
  assign mag_dy = dy[MW-1] ? MW'(-dy) : MW'(dy);
  assign mag_dd = dd[MW-1] ? MW'(-dd) : MW'(dd);

  // bit-serial multiply step and restoring divide step
  assign acc_nxt  = acc_r + (mp_r[0] ? mc_r : '0);
  assign rem_sh   = {rem_r, q_r[PW-1]};
  assign ge       = rem_sh >= {1'b0, dv_r};
  assign rem_diff = rem_sh - {1'b0, dv_r};

  assign st.step_last = cmd.mul ? (step_r == TW'(MW - 1)) : (step_r == TW'(PW - 1));

  always_ff @(posedge clk) begin
    if (cmd.prep) begin
      mc_r     <= PW'(mag_dx);
      mp_r     <= mag_dy;
      dv_r     <= mag_dd;
      acc_r    <= '0;
      step_r   <= '0;
      neg_r    <= dx[MW-1] ^ dy[MW-1] ^ dd[MW-1];
      direct_r <= (qx_r == x0_r) || (x1_r == x0_r);
    end
    if (cmd.mul) begin
      acc_r  <= acc_nxt;
      mc_r   <= mc_r << 1;
      mp_r   <= mp_r >> 1;
      if (st.step_last) begin
        step_r <= '0;
        q_r    <= acc_nxt;
        rem_r  <= '0;
      end else begin
        step_r <= step_r + TW'(1);
      end
    end
    if (cmd.div) begin
      rem_r  <= ge ? rem_diff[MW-1:0] : rem_sh[MW-1:0];
      q_r    <= {q_r[PW-2:0], ge};
      step_r <= step_r + TW'(1);
    end
  end

  // final sum with sign, then saturation
  assign y0e = SW'(y0_r);
  assign qe  = SW'({2'b00, q_r});
  assign sum = neg_r ? (y0e - qe) : (y0e + qe);
  assign ovf = (sum[SW-1:DW-1] != '0) && (sum[SW-1:DW-1] != '1);

  always_comb begin
    if (!found_r) begin
      fin_value = tli_pkg::SENTINEL;
    end else if (direct_r) begin
      fin_value = y0_r;
    end else if (ovf) begin
      fin_value = sum[SW-1] ? {1'b1, {(DW-1){1'b0}}} : {1'b0, {(DW-1){1'b1}}};
    end else begin
      fin_value = sum[DW-1:0];
    end
  end

  // output register
  assign st.out_free = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.fin && st.out_free) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.fin && st.out_free) begin
      out_value_r <= fin_value;
      out_found_r <= found_r;
    end
  end

  // status to the controller
  assign st.few    = n_eff < RW'(2);
  assign st.hit    = hit;
  assign st.miss   = cmd.scan && rvalid_r && !bracket && last_idx;
  assign st.direct = (qx_r == x0_r) || (x1_r == x0_r);

  assign out_valid = out_valid_r;
  assign out_value = out_value_r;
  assign out_found = out_found_r;

  // scan never looks at an entry at or past the point count
  a_scan_range: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.scan && rvalid_r) |-> (ridx_r < n_eff))
    else $error("scan read beyond point count");

  // a flat segment must take the direct path, never the divider
  a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.div |-> (dv_r != '0))
    else $error("divide started with zero divisor");

  // a result only appears after the finish step
  a_out_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(cmd.fin))
    else $error("result loaded outside finish step");

endmodule

// File: design/table_linear_interpolator.sv
// Piecewise linear table interpolator. A write request stores one breakpoint. A query
// request scans segments from entry 0 at one memory read per cycle until it finds the
// bracketing segment or reaches the last entry in use. An interpolated result then needs
// a prepare step, a bit-serial multiplier and a restoring divider, plus a finish step;
// an exact hit on the left breakpoint or a flat segment skips the multiply and divide.
// No further request is taken until the query's result is in the output register.
// The result sits in an output register, so the next request is taken while it waits.
// The table is not cleared at reset; query only entries already written.
module table_linear_interpolator (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_we,
  input  logic [tli_pkg::CNT_W-1:0]  cfg_wdata,
  tli_in_if.sink                     in_req,
  tli_out_if.source                  out_res
);

  tli_pkg::cmd_t  cmd;
  tli_pkg::stat_t st;

  // controller
  tli_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_req.valid),
    .in_func  (in_req.func),
    .in_ready (in_req.ready),
    .st       (st),
    .cmd      (cmd)
  );

  // datapath
  tli_dpath u_dpath (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_we      (cfg_we),
    .cfg_wdata   (cfg_wdata),
    .cmd         (cmd),
    .st          (st),
    .entry_index (in_req.entry_index),
    .entry_x     (in_req.entry_x),
    .entry_y     (in_req.entry_y),
    .query_x     (in_req.query_x),
    .out_ready   (out_res.ready),
    .out_valid   (out_res.valid),
    .out_value   (out_res.value),
    .out_found   (out_res.found)
  );

endmodule

// File: sim/table_linear_interpolator_test.sv
// testbench for the table interpolator: directed and random requests checked by a local predictor
module table_linear_interpolator_test;

  localparam int CLK_PERIOD      = 12;
  localparam int DRAIN_CYCLES    = tli_pkg::TABLE_DEPTH + 120;
  localparam int WATCHDOG_LIMIT  = 10000;
  localparam int RANDOM_PHASES   = 18;
  localparam int ITEMS_PER_PHASE = 32;
  localparam logic signed [tli_pkg::DATA_W-1:0] X_MIN = 32'sh8000_0000;
  localparam logic signed [tli_pkg::DATA_W-1:0] X_MAX = 32'sh7FFF_FFFF;

  typedef struct packed {
    logic                              func;
    logic [tli_pkg::IDX_W-1:0]         entry_index;
    logic signed [tli_pkg::DATA_W-1:0] entry_x;
    logic signed [tli_pkg::DATA_W-1:0] entry_y;
    logic signed [tli_pkg::DATA_W-1:0] query_x;
  } request_t;

  typedef struct packed {
    logic signed [tli_pkg::DATA_W-1:0] value;
    logic                              found;
  } interp_result_t;

  typedef enum int {STYLE_FULL, STYLE_WHOLE, STYLE_TINY, STYLE_EDGE} coord_style_t;
  typedef enum int {ORDER_UP, ORDER_DOWN, ORDER_MIXED} table_order_t;

  logic                      clk;
  logic                      rst_n;
  logic                      cfg_we;
  logic [tli_pkg::CNT_W-1:0] cfg_wdata;

  tli_in_if  req_if ();
  tli_out_if res_if ();

  table_linear_interpolator i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_req    (req_if),
    .out_res   (res_if)
  );

  // predictor copy of the breakpoint table and the point count
  logic signed [tli_pkg::DATA_W-1:0] bp_x [tli_pkg::TABLE_DEPTH];
  logic signed [tli_pkg::DATA_W-1:0] bp_y [tli_pkg::TABLE_DEPTH];
  logic [tli_pkg::CNT_W-1:0]         points_cfg;
  interp_result_t                    expected_results [$];
  int                                fail_count;
  int                                hold_left;
  bit                                quiet;

  // clock
  initial begin
    clk = 1'b0;
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  function automatic int effective_points();
    return (points_cfg > tli_pkg::TABLE_DEPTH) ? tli_pkg::TABLE_DEPTH : int'(points_cfg);
  endfunction

  // first bracketing segment, multiply then truncating divide, saturated sum
  function automatic interp_result_t interpolate_at(logic signed [tli_pkg::DATA_W-1:0] x);
    interp_result_t     r;
    int                 n;
    int                 i;
    longint             x0, x1, y0, dx, dy, dd;
    logic [65:0]        mag_dx, mag_dy, mag_dd, quot;
    logic signed [67:0] step, sum;
    bit                 neg;
    r.value = tli_pkg::SENTINEL;
    r.found = 1'b0;
    n = effective_points();
    for (i = 0; i + 1 < n && !r.found; i++) begin
      x0 = bp_x[i];
      x1 = bp_x[i+1];
      y0 = bp_y[i];
      if ((x >= x0 && x <= x1) || (x <= x0 && x >= x1)) begin
        r.found = 1'b1;
        if (x == x0 || x1 == x0) begin
          r.value = bp_y[i];
        end else begin
          dx = longint'(x) - x0;
          dy = longint'(bp_y[i+1]) - y0;
          dd = x1 - x0;
          mag_dx = (dx < 0) ? 66'(-dx) : 66'(dx);
          mag_dy = (dy < 0) ? 66'(-dy) : 66'(dy);
          mag_dd = (dd < 0) ? 66'(-dd) : 66'(dd);
          quot = (mag_dx * mag_dy) / mag_dd;
          neg = ((dx < 0) != (dy < 0)) != (dd < 0);
          step = neg ? -$signed({2'b00, quot}) : $signed({2'b00, quot});
          sum = step + y0;
          if (sum > 68'sd2147483647)
            r.value = X_MAX;
          else if (sum < -68'sd2147483648)
            r.value = X_MIN;
          else
            r.value = sum[tli_pkg::DATA_W-1:0];
        end
      end
    end
    return r;
  endfunction

  // update the table on a write request, queue the answer of a query request
  function automatic void record_request(request_t r);
    if (r.func == tli_pkg::FUNC_WRITE) begin
      bp_x[r.entry_index] = r.entry_x;
      bp_y[r.entry_index] = r.entry_y;
    end else begin
      expected_results.push_back(interpolate_at(r.query_x));
    end
  endfunction

  function automatic void check_result(logic signed [tli_pkg::DATA_W-1:0] value,
                                       logic found);
    interp_result_t exp_r;
    if (expected_results.size() == 0) begin
      $error("result with no query pending: value %0d found %0b", value, found);
      fail_count++;
    end else begin
      exp_r = expected_results.pop_front();
      if (value !== exp_r.value) begin
        $error("value mismatch: expected %0d actual %0d", exp_r.value, value);
        fail_count++;
      end
      if (found !== exp_r.found) begin
        $error("found mismatch: expected %0b actual %0b", exp_r.found, found);
        fail_count++;
      end
    end
  endfunction

  // mostly short gaps, a few long ones
  function automatic int pick_gap();
    int roll;
    if (quiet)
      return 0;
    roll = $urandom_range(0, 99);
    if (roll < 45)
      return 0;
    if (roll < 85)
      return $urandom_range(1, 3);
    if (roll < 97)
      return $urandom_range(4, 20);
    return $urandom_range(30, 200);
  endfunction

  function automatic logic signed [tli_pkg::DATA_W-1:0] pick_coord(coord_style_t style);
    case (style)
      STYLE_WHOLE: return (int'($urandom_range(0, 40)) - 20) <<< tli_pkg::FRAC_BITS;
      STYLE_TINY:  return int'($urandom_range(0, 2000)) - 1000;
      STYLE_EDGE: begin
        if ($urandom_range(0, 1))
          return X_MAX - int'($urandom_range(0, 65535));
        return X_MIN + int'($urandom_range(0, 65535));
      end
      default:     return $urandom();
    endcase
  endfunction

  // query x inside a random segment, on a breakpoint, next to one, or anywhere
  function automatic logic signed [tli_pkg::DATA_W-1:0] pick_query(int n);
    int     i, roll;
    longint a, b, lo, hi;
    roll = $urandom_range(0, 99);
    i = $urandom_range(0, n - 2);
    a = bp_x[i];
    b = bp_x[i+1];
    lo = (a < b) ? a : b;
    hi = (a < b) ? b : a;
    if (roll < 55)
      return tli_pkg::DATA_W'(lo + longint'($urandom()) % (hi - lo + 1));
    if (roll < 70)
      return tli_pkg::DATA_W'(a);
    if (roll < 80)
      return tli_pkg::DATA_W'(a + longint'($urandom_range(0, 2)) - 1);
    return $urandom();
  endfunction

  function automatic table_order_t pick_order();
    int roll;
    roll = $urandom_range(0, 9);
    if (roll < 6)
      return ORDER_UP;
    if (roll < 9)
      return ORDER_DOWN;
    return ORDER_MIXED;
  endfunction

  // one request, held until the block takes it
  task automatic send_request(request_t r);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_if.valid       <= 1'b1;
    req_if.func        <= r.func;
    req_if.entry_index <= r.entry_index;
    req_if.entry_x     <= r.entry_x;
    req_if.entry_y     <= r.entry_y;
    req_if.query_x     <= r.query_x;
    @(posedge clk);
    while (!req_if.ready) @(posedge clk);
    record_request(r);
  endtask

  task automatic send_write(int idx, logic signed [tli_pkg::DATA_W-1:0] x,
                            logic signed [tli_pkg::DATA_W-1:0] y);
    request_t r;
    r.func        = tli_pkg::FUNC_WRITE;
    r.entry_index = tli_pkg::IDX_W'(idx);
    r.entry_x     = x;
    r.entry_y     = y;
    r.query_x     = $urandom();
    send_request(r);
  endtask

  task automatic send_query(logic signed [tli_pkg::DATA_W-1:0] x);
    request_t r;
    r.func        = tli_pkg::FUNC_QUERY;
    r.entry_index = tli_pkg::IDX_W'($urandom());
    r.entry_x     = $urandom();
    r.entry_y     = $urandom();
    r.query_x     = x;
    send_request(r);
  endtask

  // stop offering requests until every pending result is back
  task automatic wait_results_back();
    req_if.valid <= 1'b0;
    do @(posedge clk); while (expected_results.size() != 0);
  endtask

  // also let a trailing write request finish
  task automatic wait_for_drain();
    wait_results_back();
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_points(int n);
    wait_for_drain();
    cfg_we    <= 1'b1;
    cfg_wdata <= tli_pkg::CNT_W'(n);
    @(posedge clk);
    cfg_we    <= 1'b0;
    points_cfg = tli_pkg::CNT_W'(n);
  endtask

  // fill entries 0..n-1, sorted up or down, or in no order at all
  task automatic load_table(int n, coord_style_t style, table_order_t order);
    longint xs [tli_pkg::TABLE_DEPTH];
    longint cur, step_max;
    int     i;
    case (style)
      STYLE_WHOLE: begin
        step_max = 64'sd3 <<< tli_pkg::FRAC_BITS;
        cur = -(longint'($urandom_range(0, 20)) <<< tli_pkg::FRAC_BITS);
      end
      STYLE_TINY: begin
        step_max = 200;
        cur = -longint'($urandom_range(0, 500));
      end
      default: begin
        step_max = 64'sh0_FFFF_FFFE / (n + 1);
        cur = longint'(X_MIN) + longint'($urandom()) % (step_max + 1);
      end
    endcase
    for (i = 0; i < n; i++) begin
      if (order == ORDER_MIXED) begin
        xs[i] = pick_coord(style);
      end else begin
        xs[i] = cur;
        cur += longint'($urandom()) % (step_max + 1);
      end
    end
    for (i = 0; i < n; i++) begin
      send_write((order == ORDER_DOWN) ? n - 1 - i : i, tli_pkg::DATA_W'(xs[i]),
                 $urandom_range(0, 1) ? $urandom() : pick_coord(style));
      // stray write beyond the entries in use
      if (n < tli_pkg::TABLE_DEPTH && $urandom_range(0, 5) == 0)
        send_write($urandom_range(n, tli_pkg::TABLE_DEPTH - 1), $urandom(), $urandom());
    end
  endtask

  // no points, then a single point: never found
  task automatic test_few_points();
    set_points(0);
    send_query($urandom());
    send_write(0, 32'sh0001_0000, 32'sh0002_0000);
    set_points(1);
    send_query(32'sh0001_0000);
  endtask

  // one segment spanning the whole x range with y running from max to min
  task automatic test_segment_extremes();
    send_write(0, X_MIN, X_MAX);
    send_write(1, X_MAX, X_MIN);
    set_points(2);
    send_query(X_MIN);
    send_query(X_MAX);
    send_query(0);
    send_query(1);
    send_query(-1);
  endtask

  // flat first segment, falling x, hits on segment ends, and a miss
  task automatic test_segment_shapes();
    send_write(0, 32'sh0005_0000, 100);
    send_write(1, 32'sh0005_0000, -200);
    send_write(2, -32'sh0003_0000, 32'sh7FFF_0000);
    send_write(3, 32'sh7000_0000, X_MIN);
    send_write(4, X_MIN, 32'sh1234_5678);
    set_points(5);
    send_query(32'sh0005_0000);
    send_query(32'sh0001_0000);
    send_query(-32'sh0003_0000);
    send_query(32'sh0100_0000);
    send_query(X_MIN);
    send_query(X_MAX);
  endtask

  // random tables with mostly bracketed queries and some stray writes
  task automatic test_random_tables();
    int           phase, n, k, roll;
    coord_style_t style;
    for (phase = 0; phase < RANDOM_PHASES; phase++) begin
      roll = $urandom_range(0, 99);
      if (roll < 60)
        n = $urandom_range(2, 8);
      else if (roll < 90)
        n = $urandom_range(9, 40);
      else
        n = $urandom_range(41, 120);
      style = coord_style_t'($urandom_range(0, 3));
      quiet = ($urandom_range(0, 3) == 0);
      load_table(n, style, pick_order());
      set_points(n);
      for (k = 0; k < ITEMS_PER_PHASE; k++) begin
        if ($urandom_range(0, 99) < 10)
          send_write($urandom_range(0, tli_pkg::TABLE_DEPTH - 1), pick_coord(style),
                     $urandom());
        else
          send_query(pick_query(n));
      end
    end
    quiet = 1'b0;
  endtask

  // receiver holds off long enough for the block to stall its input
  task automatic test_output_stall();
    int k;
    load_table(6, STYLE_WHOLE, ORDER_UP);
    set_points(6);
    quiet = 1'b1;
    hold_left = 600;
    for (k = 0; k < 12; k++)
      send_query(pick_query(6));
    wait_results_back();
    quiet = 1'b0;
    for (k = 0; k < 8; k++)
      send_query(pick_query(6));
  endtask

  // every entry in use, then counts beyond the table size
  task automatic test_full_table();
    int k;
    load_table(tli_pkg::TABLE_DEPTH, STYLE_FULL, ORDER_UP);
    set_points(tli_pkg::TABLE_DEPTH);
    for (k = 0; k < 14; k++)
      send_query(pick_query(tli_pkg::TABLE_DEPTH));
    send_query(X_MAX);
    send_query(X_MIN);
    set_points((1 << tli_pkg::CNT_W) - 1);
    for (k = 0; k < 10; k++)
      send_query(pick_query(tli_pkg::TABLE_DEPTH));
    set_points(tli_pkg::TABLE_DEPTH + 1 + $urandom_range(0, 200));
    for (k = 0; k < 5; k++)
      send_query(pick_query(tli_pkg::TABLE_DEPTH));
  endtask

  // result side: check each accepted result, stall at random or on a hold-off
  initial begin : receiver
    int stall_left;
    stall_left = 0;
    res_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && res_if.valid && res_if.ready)
        check_result(res_if.value, res_if.found);
      if (hold_left > 0) begin
        res_if.ready <= 1'b0;
        hold_left--;
      end else if (stall_left > 0) begin
        res_if.ready <= 1'b0;
        stall_left--;
      end else if (quiet || $urandom_range(0, 3) != 0) begin
        res_if.ready <= 1'b1;
      end else begin
        res_if.ready <= 1'b0;
        stall_left = pick_gap();
      end
    end
  end

  // watchdog on cycles with no handshake on either channel
  initial begin : watchdog
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((req_if.valid && req_if.ready) || (res_if.valid && res_if.ready))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("Test completed with failures");
    $finish;
  end

  // reset, then the tests in turn
  initial begin : main_seq
    fail_count = 0;
    hold_left  = 0;
    quiet      = 1'b0;
    points_cfg = '0;
    rst_n              <= 1'b0;
    cfg_we             <= 1'b0;
    cfg_wdata          <= '0;
    req_if.valid       <= 1'b0;
    req_if.func        <= tli_pkg::FUNC_WRITE;
    req_if.entry_index <= '0;
    req_if.entry_x     <= '0;
    req_if.entry_y     <= '0;
    req_if.query_x     <= '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    test_few_points();
    test_segment_extremes();
    test_segment_shapes();
    test_random_tables();
    test_output_stall();
    test_full_table();
    wait_for_drain();
    if (fail_count == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule
